/* design/asa_pkg.sv */
// ----------------------------------------------------------------------------
// asa_pkg
// Shared types and constants for the aligned stack allocator.
// ----------------------------------------------------------------------------
package asa_pkg;

  // Default arena geometry
  localparam int unsigned ArenaBytesDef = 4096;
  localparam int unsigned MaxAlignDef   = 128;

  // Fixed field widths
  localparam int unsigned AddrW   = 32;
  localparam int unsigned ReqW    = 13;
  localparam int unsigned AlignW  = 8;
  localparam int unsigned CapW    = 13;
  localparam int unsigned OpW     = 3;
  localparam int unsigned StatusW = 2;

  // Stream payload widths: input tdata padded to whole bytes
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 32;

  // APB
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_BASE_ADDRESS   = 1'b0,
    REG_CAPACITY_BYTES = 1'b1
  } reg_idx_e;

  typedef enum logic [OpW-1:0] {
    OP_ALLOC           = 3'd0,
    OP_ALLOC_ALIGNED   = 3'd1,
    OP_FREE_TO         = 3'd2,
    OP_FREE_TO_ALIGNED = 3'd3,
    OP_CLEAR           = 3'd4,
    OP_READ_MARKER     = 3'd5
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

endpackage

/* design/asa_ram.sv */
// ----------------------------------------------------------------------------
// asa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module asa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/aligned_stack_allocator_unit.sv */
// ----------------------------------------------------------------------------
// aligned_stack_allocator_unit
// Bump allocator over a configurable arena with aligned allocate/free.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+-----------------------------------------
//  s_axis   | in  | tvalid/tready    | tuser: opcode; tdata: request, align, rb
//  m_axis   | out | tvalid/tready    | tuser: status; tdata: result_address
//  apb      | in  | psel/penable     | base_address (0x0), capacity_bytes (0x4)
//
//  From acceptance, a request passes the execute stage, loaded along with the
//  adjustment RAM read, then the output register, loaded by the marker update.
//  One request is accepted per cycle while the output does not stall; the
//  marker register is updated only in the execute stage, so back-to-back
//  requests see each other's effect. A stalled output holds the execute stage;
//  s_axis_tready then drops. Reset clears the marker, the base address and the
//  valid flags, loads the default capacity; the adjustment RAM is not cleared.
// ----------------------------------------------------------------------------
module aligned_stack_allocator_unit #(
  parameter int unsigned ARENA_BYTES = asa_pkg::ArenaBytesDef,
  parameter int unsigned MAX_ALIGN   = asa_pkg::MaxAlignDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [asa_pkg::InDataW-1:0]   s_axis_tdata,  // [12:0] request_bytes,
                                                       // [20:13] align_bytes,
                                                       // [52:21] rollback_address
  input  logic [asa_pkg::OpW-1:0]       s_axis_tuser,  // [2:0] opcode
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [asa_pkg::OutDataW-1:0]  m_axis_tdata,  // [31:0] result_address
  output logic [asa_pkg::StatusW-1:0]   m_axis_tuser,  // [1:0] status
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [asa_pkg::ApbAddrW-1:0]  paddr,
  input  logic [asa_pkg::ApbDataW-1:0]  pwdata,
  output logic [asa_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import asa_pkg::*;

  localparam int unsigned AW     = $clog2(ARENA_BYTES);
  localparam int unsigned TopW   = $clog2(ARENA_BYTES + 1);
  localparam int unsigned CalcW  = ((TopW > ReqW) ? TopW : ReqW) + 2;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [AddrW-1:0] base_q;
  logic [CapW-1:0]  cap_q;
  logic             cfg_wr;
  reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      cap_q  <= CapW'(ArenaBytesDef);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_BASE_ADDRESS:   base_q <= pwdata[AddrW-1:0];
        REG_CAPACITY_BYTES: cap_q  <= pwdata[CapW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_BASE_ADDRESS:   prdata = base_q;
      REG_CAPACITY_BYTES: prdata = ApbDataW'(cap_q);
      default:            prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input unpack and accept stage
  // --------------------------------------------------------------------------
  logic [ReqW-1:0]   in_req;
  logic [AlignW-1:0] in_align;
  logic [AddrW-1:0]  in_rb;
  logic [AddrW-1:0]  in_off;
  logic [AW-1:0]     rd_addr;
  logic              in_fire;

  assign in_req   = s_axis_tdata[ReqW-1:0];
  assign in_align = s_axis_tdata[ReqW+AlignW-1:ReqW];
  assign in_rb    = s_axis_tdata[ReqW+AlignW+AddrW-1:ReqW+AlignW];
  assign in_off   = in_rb - base_q;
  assign rd_addr  = AW'(in_off - AddrW'(1));
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  // Execute stage registers
  logic              s1_valid_q;
  opcode_e           s1_op_q;
  logic [ReqW-1:0]   s1_req_q;
  logic [AlignW-1:0] s1_align_q;
  logic [AddrW-1:0]  s1_off_q;
  logic              byp_hit_q;
  logic [AlignW-1:0] byp_data_q;
  logic              s1_fire;

  logic              out_valid_q;
  logic [AddrW-1:0]  out_addr_q;
  status_e           out_status_q;

  logic [TopW-1:0]   top_q;
  logic [TopW-1:0]   top_d;

  // RAM write side, driven by the execute stage
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AlignW-1:0] ram_wdata;
  logic [AlignW-1:0] ram_rdata;

  assign s1_fire       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  // Payload and bypass of a same-edge RAM write
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q    <= opcode_e'(s_axis_tuser);
      s1_req_q   <= in_req;
      s1_align_q <= in_align;
      s1_off_q   <= in_off;
      byp_hit_q  <= ram_we && (ram_waddr == rd_addr);
      byp_data_q <= ram_wdata;
    end
  end

  asa_ram #(
    .WIDTH (AlignW),
    .DEPTH (ARENA_BYTES)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Execute: marker arithmetic
  // --------------------------------------------------------------------------
  logic [AddrW-1:0]  marker;
  logic [CalcW-1:0]  cap_ext;
  logic [CalcW-1:0]  arena_ext;
  logic [CalcW-1:0]  eff_cap;
  logic [CalcW-1:0]  top_ext;
  logic [CalcW-1:0]  plain_end;
  logic [CalcW-1:0]  aligned_end;
  logic [CalcW-1:0]  slot;
  logic              align_ok;
  logic [AlignW-1:0] align_mask;
  logic [AlignW-1:0] adj_new;
  logic [AlignW-1:0] adj_rd;
  logic [AddrW-1:0]  top32;
  logic [AddrW-1:0]  off_back;
  logic              off_gt_top;

  assign marker      = base_q + AddrW'(top_q);
  assign cap_ext     = CalcW'(cap_q);
  assign arena_ext   = CalcW'(ARENA_BYTES);
  assign eff_cap     = (cap_ext < arena_ext) ? cap_ext : arena_ext;
  assign top_ext     = CalcW'(top_q);
  assign plain_end   = top_ext + CalcW'(s1_req_q);
  assign aligned_end = plain_end + CalcW'(s1_align_q);
  assign align_mask  = s1_align_q - AlignW'(1);
  assign align_ok    = (s1_align_q != '0) && (CalcW'(s1_align_q) <= CalcW'(MAX_ALIGN)) &&
                       ((s1_align_q & align_mask) == '0);
  assign adj_new     = s1_align_q - (marker[AlignW-1:0] & align_mask);
  assign slot        = top_ext + CalcW'(adj_new) - CalcW'(1);
  assign adj_rd      = byp_hit_q ? byp_data_q : ram_rdata;
  assign top32       = AddrW'(top_q);
  assign off_back    = s1_off_q - AddrW'(adj_rd);
  assign off_gt_top  = s1_off_q > top32;

  assign ram_waddr = AW'(slot);
  assign ram_wdata = adj_new;

  logic [AddrW-1:0] res_addr;
  status_e          res_status;
  logic             res_we;

  always_comb begin
    res_addr   = marker;
    res_status = ST_OK;
    res_we     = 1'b0;
    top_d      = top_q;
    unique case (s1_op_q)
      OP_ALLOC: begin
        if (plain_end > eff_cap) begin
          res_status = ST_FULL;
          res_addr   = '0;
        end else begin
          top_d = TopW'(plain_end);
        end
      end
      OP_ALLOC_ALIGNED: begin
        if (!align_ok) begin
          res_status = ST_BAD;
          res_addr   = '0;
        end else if (aligned_end > eff_cap) begin
          res_status = ST_FULL;
          res_addr   = '0;
        end else begin
          res_we   = slot < arena_ext;
          res_addr = marker + AddrW'(adj_new);
          top_d    = TopW'(aligned_end);
        end
      end
      OP_FREE_TO: begin
        if (off_gt_top) begin
          res_status = ST_BAD;
        end else begin
          top_d    = TopW'(s1_off_q);
          res_addr = base_q + s1_off_q;
        end
      end
      OP_FREE_TO_ALIGNED: begin
        if ((s1_off_q == '0) || off_gt_top ||
            ((s1_off_q - AddrW'(1)) >= AddrW'(ARENA_BYTES))) begin
          res_status = ST_BAD;
        end else if (AddrW'(adj_rd) > s1_off_q) begin
          res_status = ST_BAD;
        end else begin
          top_d    = TopW'(off_back);
          res_addr = base_q + off_back;
        end
      end
      OP_CLEAR: begin
        top_d    = '0;
        res_addr = base_q;
      end
      OP_READ_MARKER: ;
      default: res_status = ST_BAD;
    endcase
  end

  assign ram_we = s1_fire && res_we;

  // Marker register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
    end else if (s1_fire) begin
      top_q <= top_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_addr_q   <= res_addr;
      out_status_q <= res_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_addr_q;
  assign m_axis_tuser  = out_status_q;

endmodule

/* design/asa_checker.sv */
// ----------------------------------------------------------------------------
// asa_checker
// Port-level checks on the allocator's streams, bound to the top level.
// ----------------------------------------------------------------------------
module asa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [asa_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [asa_pkg::StatusW-1:0]  m_axis_tuser
);
  import asa_pkg::*;

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Only defined status codes
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_FULL) ||
                      (m_axis_tuser == ST_BAD))
    else $error("undefined status code");

  // A full arena returns a null address
  a_full_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> (m_axis_tdata == '0))
    else $error("full status with nonzero address");

  // A fresh result follows a request transaction through the execute stage and the output register
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a matching request");

  // An empty output register never blocks requests
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("request blocked with empty output");

endmodule

bind aligned_stack_allocator_unit asa_checker u_asa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* test/tb_aligned_stack_allocator_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aligned_stack_allocator_unit
// Self-checking bench for the aligned stack allocator. A queue of requests
// feeds a stream driver, and an in-bench allocator model predicts every
// result. A monitor compares each result transaction with the oldest
// prediction. Arena base and capacity change between phases, only while the
// block is drained, and the phases vary the mix of input gaps and output
// backpressure.
// ----------------------------------------------------------------------------
module tb_aligned_stack_allocator_unit;
  import asa_pkg::*;

  localparam int unsigned DRAIN_CYCLES   = 6;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned MAX_SHOWN      = 10;
  localparam int unsigned MARK_DEPTH     = 32;
  // Two copies of allocator state: one steers generation, one checks results
  localparam int          PLAN_COPY      = 0;
  localparam int          LIVE_COPY      = 1;
  // Opcodes the block does not define
  localparam logic [OpW-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OpW-1:0] OP_UNUSED_7 = 3'd7;

  typedef struct {
    logic [OpW-1:0]    op;
    logic [ReqW-1:0]   req;
    logic [AlignW-1:0] align;
    logic [AddrW-1:0]  rb;
  } alloc_req_t;

  typedef struct {
    logic [AddrW-1:0]   addr;
    logic [StatusW-1:0] status;
  } alloc_resp_t;

  // DUT signals
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata  = '0;  // [12:0] request_bytes, [20:13] align_bytes,
                                              // [52:21] rollback_address, [55:53] zero
  logic [OpW-1:0]        s_axis_tuser  = '0;  // [2:0] opcode
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;        // [31:0] result_address
  logic [StatusW-1:0]    m_axis_tuser;        // [1:0] status
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [ApbAddrW-1:0]   paddr         = '0;
  logic [ApbDataW-1:0]   pwdata        = '0;
  logic [ApbDataW-1:0]   prdata;
  logic                  pready;

  // Allocator model state
  logic [AddrW-1:0]      base_cfg     = '0;
  int unsigned           capacity_cfg = 4096;
  int unsigned           marker_off [0:1];
  logic [7:0]            adj_mem     [0:1][0:ArenaBytesDef-1];
  bit                    adj_written [0:1][0:ArenaBytesDef-1];

  // Bench bookkeeping
  alloc_req_t            pending_requests [$];
  alloc_resp_t           expected_results [$];
  logic [AddrW-1:0]      plain_marks [$];
  logic [AddrW-1:0]      aligned_marks [$];
  alloc_req_t            cur_req;
  int unsigned           send_idle_pct  = 0;
  int unsigned           recv_stall_pct = 0;
  int unsigned           error_count    = 0;
  int unsigned           results_seen   = 0;
  int unsigned           idle_cycles    = 0;

  aligned_stack_allocator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  function automatic void note_error(string msg);
    if (error_count < MAX_SHOWN) $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endfunction

  // Allocator model: applies one request to state copy c, returns the result
  function automatic alloc_resp_t allocator_predict(int c, alloc_req_t r);
    alloc_resp_t      res;
    logic [AddrW-1:0] off;
    logic [AddrW-1:0] adj;
    logic [AddrW-1:0] slot;
    int unsigned      top;
    int unsigned      cap;
    top        = marker_off[c];
    cap        = (capacity_cfg < ArenaBytesDef) ? capacity_cfg : ArenaBytesDef;
    res.addr   = base_cfg + top;
    res.status = ST_OK;
    off        = r.rb - base_cfg;
    case (r.op)
      OP_ALLOC: begin
        if (top + r.req > cap) begin
          res.status = ST_FULL;
          res.addr   = '0;
        end else begin
          marker_off[c] = top + r.req;
        end
      end
      OP_ALLOC_ALIGNED: begin
        if (r.align == 8'd0 || r.align > MaxAlignDef ||
            (r.align & (r.align - 8'd1)) != 8'd0) begin
          res.status = ST_BAD;
          res.addr   = '0;
        end else if (top + r.req + r.align > cap) begin
          res.status = ST_FULL;
          res.addr   = '0;
        end else begin
          // round up by 1..align; the pad byte below the result keeps the amount
          adj  = {24'd0, r.align} - (res.addr & ({24'd0, r.align} - 32'd1));
          slot = top + adj - 32'd1;
          if (slot < ArenaBytesDef) begin
            adj_mem[c][slot]     = adj[7:0];
            adj_written[c][slot] = 1'b1;
          end
          res.addr      = res.addr + adj;
          marker_off[c] = top + r.req + r.align;
        end
      end
      OP_FREE_TO: begin
        if (off > top) begin
          res.status = ST_BAD;
        end else begin
          marker_off[c] = off;
          res.addr      = base_cfg + off;
        end
      end
      OP_FREE_TO_ALIGNED: begin
        if (off == 0 || off > top || off - 32'd1 >= ArenaBytesDef) begin
          res.status = ST_BAD;
        end else begin
          adj = {24'd0, adj_mem[c][off - 32'd1]};
          if (adj > off) begin
            res.status = ST_BAD;
          end else begin
            marker_off[c] = off - adj;
            res.addr      = base_cfg + off - adj;
          end
        end
      end
      OP_CLEAR: begin
        marker_off[c] = 0;
        res.addr      = base_cfg;
      end
      OP_READ_MARKER: ;
      default: res.status = ST_BAD;
    endcase
    return res;
  endfunction

  // Queue one request and advance the planning copy of the model
  function automatic alloc_resp_t queue_req(logic [OpW-1:0] op, logic [ReqW-1:0] req,
                                            logic [AlignW-1:0] align, logic [AddrW-1:0] rb);
    alloc_req_t       item;
    alloc_resp_t      res;
    logic [AddrW-1:0] off;
    off = rb - base_cfg;
    // never aim an aligned free at a pad byte that no aligned allocation wrote
    if (op == OP_FREE_TO_ALIGNED && off != 0 && off <= marker_off[PLAN_COPY] &&
        off <= ArenaBytesDef && !adj_written[PLAN_COPY][off - 32'd1])
      rb = base_cfg;
    item.op    = op;
    item.req   = req;
    item.align = align;
    item.rb    = rb;
    res = allocator_predict(PLAN_COPY, item);
    pending_requests.push_back(item);
    if (res.status == ST_OK && op == OP_ALLOC) plain_marks.push_back(res.addr);
    if (res.status == ST_OK && op == OP_ALLOC_ALIGNED) aligned_marks.push_back(res.addr);
    // drop markers that now lie above the top of the stack
    while (plain_marks.size() != 0 && plain_marks[$] - base_cfg > marker_off[PLAN_COPY])
      void'(plain_marks.pop_back());
    while (aligned_marks.size() != 0 && aligned_marks[$] - base_cfg > marker_off[PLAN_COPY])
      void'(aligned_marks.pop_back());
    if (plain_marks.size() > MARK_DEPTH) void'(plain_marks.pop_front());
    if (aligned_marks.size() > MARK_DEPTH) void'(aligned_marks.pop_front());
    return res;
  endfunction

  // Random request, mostly pushes and pops that match earlier allocations
  function automatic void queue_random_req();
    int unsigned       pick;
    int unsigned       top;
    logic [OpW-1:0]    op;
    logic [ReqW-1:0]   req;
    logic [AlignW-1:0] align;
    logic [AddrW-1:0]  rb;
    top  = marker_off[PLAN_COPY];
    pick = $urandom_range(99);
    case ($urandom_range(9))
      0:       req = ReqW'($urandom_range(8191));
      1, 2:    req = ReqW'($urandom_range(512));
      default: req = ReqW'($urandom_range(48));
    endcase
    if ($urandom_range(6) == 0) align = AlignW'($urandom_range(255));
    else align = 8'd1 << $urandom_range(7);
    rb = $urandom;
    if (pick < 22) begin
      op = OP_ALLOC;
    end else if (pick < 44) begin
      op = OP_ALLOC_ALIGNED;
    end else if (pick < 58) begin
      op = OP_FREE_TO;
      case ($urandom_range(3))
        0, 1: if (plain_marks.size() != 0)
                rb = plain_marks[$urandom_range(plain_marks.size() - 1)];
        2:    rb = base_cfg + $urandom_range(top);
        default: ;
      endcase
    end else if (pick < 76) begin
      op = OP_FREE_TO_ALIGNED;
      if ($urandom_range(3) != 0 && aligned_marks.size() != 0) begin
        if ($urandom_range(1)) rb = aligned_marks[$];
        else rb = aligned_marks[$urandom_range(aligned_marks.size() - 1)];
      end else if ($urandom_range(1)) begin
        rb = base_cfg + $urandom_range(top);
      end
    end else if (pick < 81) begin
      op = OP_CLEAR;
    end else if (pick < 92) begin
      op = OP_READ_MARKER;
    end else begin
      op = $urandom_range(1) ? OP_UNUSED_6 : OP_UNUSED_7;
    end
    void'(queue_req(op, req, align, rb));
  endfunction

  // Block until every request is sent and every result is back
  task automatic wait_drained();
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Register write followed by a read-back
  task automatic write_register(reg_idx_e idx, logic [ApbDataW-1:0] val);
    logic [ApbDataW-1:0] mask;
    mask = (idx == REG_BASE_ADDRESS) ? 32'hFFFF_FFFF : 32'h0000_1FFF;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_BASE_ADDRESS) base_cfg = val;
    else capacity_cfg = val & mask;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((prdata & mask) !== (val & mask))
      note_error($sformatf("register %s read back %h, wrote %h", idx.name(), prdata, val));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Leave a known marker, drain, then reprogram the arena and the gap mix
  task automatic configure_phase(logic [AddrW-1:0] base, int unsigned cap,
                                 int unsigned send_pct, int unsigned recv_pct);
    void'(queue_req(OP_CLEAR, '0, 8'd1, '0));
    void'(queue_req(OP_ALLOC, 13'd300, 8'd1, '0));
    wait_drained();
    write_register(REG_BASE_ADDRESS, base);
    write_register(REG_CAPACITY_BYTES, cap);
    plain_marks.delete();
    aligned_marks.delete();
    @(negedge clk_i);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Request driver: predicts each accepted transaction, then loads the next
  always @(posedge clk_i) begin : request_driver
    alloc_resp_t res;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        res = allocator_predict(LIVE_COPY, cur_req);
        expected_results.push_back(res);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req       = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {3'b000, cur_req.rb, cur_req.align, cur_req.req};
          s_axis_tuser  <= cur_req.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random backpressure
  always @(posedge clk_i) begin : result_monitor
    alloc_resp_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          note_error($sformatf("result %0d arrived with none pending: addr %h status %0d",
                               results_seen, m_axis_tdata, m_axis_tuser));
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata !== want.addr || m_axis_tuser !== want.status)
            note_error($sformatf("result %0d: expected addr %h status %0d, got addr %h status %0d",
                                 results_seen, want.addr, want.status,
                                 m_axis_tdata, m_axis_tuser));
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || psel || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    alloc_resp_t a1, a2, a3;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero base, full arena, no gaps
    configure_phase(32'h0, 4096, 0, 0);
    void'(queue_req(OP_READ_MARKER, '0, 8'd1, '0));
    void'(queue_req(OP_CLEAR, '0, 8'd1, '0));
    void'(queue_req(OP_ALLOC, 13'd0, 8'd1, '0));
    void'(queue_req(OP_ALLOC, 13'd1, 8'd1, '0));
    a1 = queue_req(OP_ALLOC_ALIGNED, 13'd10, 8'd128, '0);
    a2 = queue_req(OP_ALLOC_ALIGNED, 13'd0, 8'd1, '0);
    // rejected alignments: zero, not a power of two, above the maximum
    void'(queue_req(OP_ALLOC_ALIGNED, 13'd5, 8'd0, '0));
    void'(queue_req(OP_ALLOC_ALIGNED, 13'd5, 8'd3, '0));
    void'(queue_req(OP_ALLOC_ALIGNED, 13'd5, 8'd255, '0));
    // aligned frees unwind in stack order
    void'(queue_req(OP_FREE_TO_ALIGNED, '0, 8'd1, a2.addr));
    void'(queue_req(OP_FREE_TO_ALIGNED, '0, 8'd1, a1.addr));
    void'(queue_req(OP_FREE_TO_ALIGNED, '0, 8'd1, base_cfg));
    // markers above the top, including a wrapped offset
    void'(queue_req(OP_FREE_TO, '0, 8'd1, base_cfg + 32'd4000));
    void'(queue_req(OP_FREE_TO, '0, 8'd1, 32'hFFFF_FFFF));
    void'(queue_req(OP_ALLOC, 13'd4096, 8'd1, '0));
    void'(queue_req(OP_CLEAR, '0, 8'd1, '0));
    // exact fill, then any request that needs more space reports full
    void'(queue_req(OP_ALLOC, 13'd4096, 8'd1, '0));
    void'(queue_req(OP_ALLOC, 13'd0, 8'd1, '0));
    void'(queue_req(OP_ALLOC, 13'd1, 8'd1, '0));
    void'(queue_req(OP_ALLOC_ALIGNED, 13'd0, 8'd1, '0));
    void'(queue_req(OP_FREE_TO, '0, 8'd1, base_cfg + 32'd4096));
    void'(queue_req(OP_CLEAR, '0, 8'd1, '0));
    void'(queue_req(OP_ALLOC, 13'd8191, 8'd1, '0));
    a3 = queue_req(OP_ALLOC_ALIGNED, 13'd3968, 8'd128, '0);
    void'(queue_req(OP_FREE_TO_ALIGNED, '0, 8'd1, a3.addr));
    void'(queue_req(OP_FREE_TO, '0, 8'd1, base_cfg));
    void'(queue_req(OP_UNUSED_6, 13'h1FFF, 8'hFF, 32'hFFFF_FFFF));
    void'(queue_req(OP_UNUSED_7, '0, 8'd1, '0));
    void'(queue_req(OP_READ_MARKER, '0, 8'd1, '0));
    repeat (225) queue_random_req();

    // Arena at the top of the address space, sparse requests
    configure_phase(32'hFFFF_FF80, 4096, 76, 0);
    repeat (300) queue_random_req();

    // One-byte capacity below the marker, heavy backpressure
    configure_phase($urandom & ~32'h7F, 1, 0, 76);
    repeat (150) queue_random_req();

    // Random arena, light gaps on both sides
    configure_phase($urandom & ~32'h7F, $urandom_range(64, 4096), 22, 22);
    repeat (350) queue_random_req();

    // Mid-size arena, full rate
    configure_phase(32'h0000_0080, 2048, 0, 0);
    repeat (250) queue_random_req();

    wait_drained();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
